// ===== hw/rtl/sta_pkg.sv =====
// Shared types and constants for the slot table allocator.
`timescale 1ns / 1ps
package sta_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int SLOT_W        = 8;
   localparam int HANDLE_W      = 32;
   localparam int OP_W          = 3;
   localparam int REQ_W         = 48;   // 43 payload bits padded to bytes
   localparam int RSP_W         = 48;   // 41 payload bits padded to bytes

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 3'd0,
      OP_MAIN    = 3'd1,
      OP_GET     = 3'd2,
      OP_RELEASE = 3'd3,
      OP_FIND    = 3'd4
   } op_type;

   // request token walking down the cell chain
   typedef struct packed {
      logic                active;
      logic [OP_W-1:0]     op;
      logic [SLOT_W-1:0]   idx;
      logic                oor;        // index beyond table
      logic [HANDLE_W-1:0] handle;     // handle to store or to match
      logic                done;       // a cell already claimed or matched
      logic [SLOT_W-1:0]   slot;       // slot claimed or matched
      logic [HANDLE_W-1:0] rd_handle;  // handle read by get
   } tok_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

endpackage

// ===== hw/rtl/sta_cell.sv =====
// One slot of the table: used flag, handle and one token stage.
`timescale 1ns / 1ps
module sta_cell #(
   parameter int INDEX = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  sta_pkg::tok_type tok_i,
   output sta_pkg::tok_type tok_o
);
   import sta_pkg::*;

   localparam logic             ALLOC_OK = (INDEX >= 2);
   localparam logic             MAIN_OK  = (INDEX == 1);
   localparam logic             FIND_OK  = (INDEX >= 1);
   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic                used_ff,   used_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   tok_type             tok_ff,    tok_in;

   logic idx_hit, alloc_hit, main_hit, get_hit, rel_hit, find_hit;

   always_comb begin
      idx_hit   = (tok_i.idx == MY_SLOT);
      alloc_hit = tok_i.active && (tok_i.op == OP_ALLOC) && !tok_i.done && !used_ff
                  && ALLOC_OK;
      main_hit  = tok_i.active && (tok_i.op == OP_MAIN) && MAIN_OK;
      get_hit   = tok_i.active && (tok_i.op == OP_GET) && idx_hit;
      rel_hit   = tok_i.active && (tok_i.op == OP_RELEASE) && idx_hit;
      find_hit  = tok_i.active && (tok_i.op == OP_FIND) && !tok_i.done && FIND_OK
                  && (handle_ff == tok_i.handle);

      used_in   = used_ff;
      handle_in = handle_ff;
      if (alloc_hit || main_hit) begin
         used_in   = 1'b1;
         handle_in = tok_i.handle;
      end else if (rel_hit) begin
         used_in   = 1'b0;
         handle_in = '0;
      end

      tok_in = tok_i;
      if (alloc_hit || find_hit) begin
         tok_in.done = 1'b1;
         tok_in.slot = MY_SLOT;
      end
      if (get_hit) begin
         tok_in.rd_handle = handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         handle_ff     <= '0;
         tok_ff.active <= 1'b0;
      end else begin
         used_ff       <= used_in;
         handle_ff     <= handle_in;
         tok_ff.active <= tok_in.active;
      end
      tok_ff.op        <= tok_in.op;
      tok_ff.idx       <= tok_in.idx;
      tok_ff.oor       <= tok_in.oor;
      tok_ff.handle    <= tok_in.handle;
      tok_ff.done      <= tok_in.done;
      tok_ff.slot      <= tok_in.slot;
      tok_ff.rd_handle <= tok_in.rd_handle;
   end

   assign tok_o = tok_ff;

endmodule

// ===== hw/rtl/slot_table_allocator_core.sv =====
// Top level: slot table allocator built as a chain of slot cells.
// A request item is taken only while the sequencer is idle; the request token
// steps through one slot cell per cycle, and the whole chain is always traversed
// before the result reaches the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) frees all slots and zeroes all handles at once.
`timescale 1ns / 1ps
module slot_table_allocator_core #(
   parameter int SLOTS = sta_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sta_pkg::REQ_W-1:0] req_tdata,  // opcode[2:0], slot_index[10:3],
                                                 // object_handle[42:11], zero pad
   // result channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sta_pkg::RSP_W-1:0] rsp_tdata   // status[0], result_slot[8:1],
                                                 // result_handle[40:9], zero pad
);
   import sta_pkg::*;

   localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);
   localparam int              PAD_W      = RSP_W - 1 - SLOT_W - HANDLE_W;

   // token chain: tok[0] enters cell 0, tok[SLOTS] leaves the last cell
   tok_type           tok [0:SLOTS];
   tok_type           tok_launch;
   logic [SLOTS-1:0]  chain_active;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_W-1:0]  pend_ff, pend_in;

   logic              req_accept;
   logic              out_free;
   logic              res_status;
   logic [SLOT_W-1:0] res_slot;
   logic [HANDLE_W-1:0] res_handle;
   logic [RSP_W-1:0]  res_word;
   tok_type           tok_exit;

   assign req_accept = req_tvalid && req_tready;

   // launch token
   always_comb begin
      tok_launch           = '0;
      tok_launch.active    = req_accept;
      tok_launch.op        = req_tdata[OP_W-1:0];
      tok_launch.idx       = req_tdata[OP_W +: SLOT_W];
      tok_launch.handle    = req_tdata[OP_W+SLOT_W +: HANDLE_W];
      tok_launch.oor       = !({1'b0, req_tdata[OP_W +: SLOT_W]} < SLOT_LIMIT);
   end

   assign tok[0] = tok_launch;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      sta_cell #(
         .INDEX(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .tok_i(tok[g]),
         .tok_o(tok[g+1])
      );
      assign chain_active[g] = tok[g+1].active;
   end

   assign tok_exit = tok[SLOTS];

   // final result from the token leaving the chain
   always_comb begin
      res_status = 1'b1;
      res_slot   = '0;
      res_handle = '0;
      case (tok_exit.op)
         OP_ALLOC, OP_FIND: begin
            res_status = !tok_exit.done;
            res_slot   = tok_exit.done ? tok_exit.slot : '0;
         end
         OP_MAIN: begin
            res_status = 1'b0;
            res_slot   = SLOT_W'(1);
         end
         OP_GET: begin
            res_status = tok_exit.oor;
            res_handle = tok_exit.oor ? '0 : tok_exit.rd_handle;
         end
         OP_RELEASE: begin
            res_status = tok_exit.oor;
         end
         default: begin
            res_status = 1'b1;   // unknown opcode
         end
      endcase
      res_word = {{PAD_W{1'b0}}, res_handle, res_slot, res_status};
   end

   // sequencer and output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_exit.active) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = res_word;
                  state_in     = ST_IDLE;
               end else begin
                  pend_in  = res_word;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // at most one request token in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_active))
      else $error("more than one token in the slot chain");

   // an accepted item launches a token into the first cell
   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> chain_active[0])
      else $error("accepted item did not enter the chain");

   // a held result only exists while the output register is occupied
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("result held while output register is empty");

   // no token in flight while idle
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (chain_active == '0))
      else $error("token in chain while sequencer idle");
`endif

endmodule
